FILE: hdl/hsv_pkg.sv
package hsv_pkg;

  // Hue is carried in 1/64 degree; one sector of 60 degrees is 3840 units.
  localparam int HUE_BITS   = 15;
  localparam int HUE_Q_BITS = 12;
  localparam int HUE_SHIFT_HI = 12;
  localparam int HUE_SHIFT_LO = 8;
  localparam int MIN_STEPS  = 12;

  localparam logic [HUE_BITS-1:0] HUE_FULL     = 15'd23040;
  localparam logic [HUE_BITS-1:0] OFFSET_RED   = 15'd0;
  localparam logic [HUE_BITS-1:0] OFFSET_GREEN = 15'd7680;
  localparam logic [HUE_BITS-1:0] OFFSET_BLUE  = 15'd15360;

  // Sector codes: which component holds the maximum.
  localparam logic [1:0] SECT_RED   = 2'd0;
  localparam logic [1:0] SECT_GREEN = 2'd1;
  localparam logic [1:0] SECT_BLUE  = 2'd2;

  // Control that travels alongside each pixel through the divider row.
  typedef struct packed {
    logic       valid;
    logic [1:0] sector;
    logic       neg;
    logic       gray;
  } hsv_ctl_t;

endpackage

FILE: hdl/hsv_front.sv
module hsv_front #(
  parameter int W = 8,
  parameter int S = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [W-1:0]     red,
  input  logic [W-1:0]     green,
  input  logic [W-1:0]     blue,
  output hsv_pkg::hsv_ctl_t ctl,
  output logic [W-1:0]     sat_div,
  output logic [W-1:0]     hue_div,
  output logic [W-1:0]     sat_rem,
  output logic [S-1:0]     sat_dvd,
  output logic [W-1:0]     hue_rem,
  output logic [S-1:0]     hue_dvd
);
  import hsv_pkg::*;

  localparam int DW = S + W;

  logic [W-1:0]  mx, mn, delta, opa, opb, absdiff;
  logic [1:0]    sector;
  logic          neg;
  logic [DW-1:0] sat_full, hue_full;

  // Find the extremes and the sector, with red winning ties over green over blue.
  always_comb begin
    mx = (red > green) ? red : green;
    mn = (red < green) ? red : green;
    if (blue > mx) mx = blue;
    if (blue < mn) mn = blue;
    delta = mx - mn;
    if (red >= mx) begin
      sector = SECT_RED;
      opa = green;
      opb = blue;
    end else if (green >= mx) begin
      sector = SECT_GREEN;
      opa = blue;
      opb = red;
    end else begin
      sector = SECT_BLUE;
      opa = red;
      opb = green;
    end
    neg = opa < opb;
    absdiff = neg ? (opb - opa) : (opa - opb);
  end

  // Dividends: full scale times delta, and 3840 times the difference, by shift and subtract.
  assign sat_full = (DW'(delta) << W) - DW'(delta);
  assign hue_full = (DW'(absdiff) << HUE_SHIFT_HI) - (DW'(absdiff) << HUE_SHIFT_LO);

  // Register the beat into the head of the divider row.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid  <= start;
      ctl.sector <= sector;
      ctl.neg    <= neg;
      ctl.gray   <= (delta == '0);
    end
    sat_div <= mx;
    hue_div <= delta;
    sat_rem <= sat_full[DW-1:S];
    sat_dvd <= sat_full[S-1:0];
    hue_rem <= hue_full[DW-1:S];
    hue_dvd <= hue_full[S-1:0];
  end

endmodule

FILE: hdl/hsv_div_cell.sv
module hsv_div_cell #(
  parameter int W = 8,
  parameter int S = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  hsv_pkg::hsv_ctl_t ctl_in,
  input  logic [W-1:0]      sat_div_in,
  input  logic [W-1:0]      hue_div_in,
  input  logic [W-1:0]      sat_rem_in,
  input  logic [S-1:0]      sat_dvd_in,
  input  logic [W-1:0]      hue_rem_in,
  input  logic [S-1:0]      hue_dvd_in,
  output hsv_pkg::hsv_ctl_t ctl_out,
  output logic [W-1:0]      sat_div_out,
  output logic [W-1:0]      hue_div_out,
  output logic [W-1:0]      sat_rem_out,
  output logic [S-1:0]      sat_dvd_out,
  output logic [W-1:0]      hue_rem_out,
  output logic [S-1:0]      hue_dvd_out
);
  import hsv_pkg::*;

  logic [W:0] sat_trial, hue_trial, sat_diff, hue_diff;
  logic       sat_bit, hue_bit;

  // One restoring step for each division: shift in the next dividend bit and try a subtract.
  always_comb begin
    sat_trial = {sat_rem_in, sat_dvd_in[S-1]};
    hue_trial = {hue_rem_in, hue_dvd_in[S-1]};
    sat_diff  = sat_trial - {1'b0, sat_div_in};
    hue_diff  = hue_trial - {1'b0, hue_div_in};
    sat_bit   = sat_trial >= {1'b0, sat_div_in};
    hue_bit   = hue_trial >= {1'b0, hue_div_in};
  end

  // Hand the partial results to the next cell; quotient bits fill the dividend register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    sat_div_out <= sat_div_in;
    hue_div_out <= hue_div_in;
    sat_rem_out <= sat_bit ? sat_diff[W-1:0] : sat_trial[W-1:0];
    hue_rem_out <= hue_bit ? hue_diff[W-1:0] : hue_trial[W-1:0];
    sat_dvd_out <= {sat_dvd_in[S-2:0], sat_bit};
    hue_dvd_out <= {hue_dvd_in[S-2:0], hue_bit};
  end

endmodule

FILE: hdl/hsv_back.sv
module hsv_back #(
  parameter int W = 8,
  parameter int S = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  hsv_pkg::hsv_ctl_t ctl,
  input  logic [W-1:0]      value_in,
  input  logic [S-1:0]      sat_quo,
  input  logic [S-1:0]      hue_quo,
  output logic              done,
  output logic [hsv_pkg::HUE_BITS-1:0] hue,
  output logic [W-1:0]      saturation,
  output logic [W-1:0]      brightness
);
  import hsv_pkg::*;

  logic [HUE_BITS-1:0] offset, quo;
  logic [HUE_BITS:0]   sum;
  logic [HUE_BITS-1:0] hue_next;

  // Add the sector offset to the signed quotient and wrap a negative angle.
  always_comb begin
    case (ctl.sector)
      SECT_RED:   offset = OFFSET_RED;
      SECT_GREEN: offset = OFFSET_GREEN;
      SECT_BLUE:  offset = OFFSET_BLUE;
      default:    offset = OFFSET_RED;
    endcase
    quo = HUE_BITS'(hue_quo[HUE_Q_BITS-1:0]);
    sum = ctl.neg ? ({1'b0, offset} - {1'b0, quo}) : ({1'b0, offset} + {1'b0, quo});
    if (sum[HUE_BITS]) begin
      hue_next = sum[HUE_BITS-1:0] + HUE_FULL;
    end else begin
      hue_next = sum[HUE_BITS-1:0];
    end
  end

  // Output register; a gray pixel reports zero hue and saturation.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.valid;
    end
    hue        <= ctl.gray ? '0 : hue_next;
    saturation <= ctl.gray ? '0 : sat_quo[W-1:0];
    brightness <= value_in;
  end

endmodule

FILE: hdl/rgb_to_hsv_converter.sv
// RGB to HSV converter.
// Input: drive red, green and blue and raise start for one cycle; the beat is
// taken at the clock edge where start is high and busy is low. busy stays low,
// so a new pixel can be given in every cycle.
// Output: done is high for exactly one cycle with hue (1/64 degree, 0..23039),
// saturation (full scale = 1.0) and brightness (the largest component).
// Results leave in the order the pixels arrived; the receiver must take each
// beat in the cycle it appears, since it cannot hold results off.
// STEPS is the larger of 12 and COMPONENT_BITS. One register sets up the
// dividends, a row of STEPS divider cells resolves one quotient bit each for
// both saturation and hue, and an output register adds the sector offset.
// Throughput: one pixel per clock.
// Reset (rst, synchronous) clears the valid bits along the row, so done stays
// low until pixels accepted after reset emerge.
module rgb_to_hsv_converter #(
  parameter int COMPONENT_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [COMPONENT_BITS-1:0]     red,
  input  logic [COMPONENT_BITS-1:0]     green,
  input  logic [COMPONENT_BITS-1:0]     blue,
  output logic                          done,
  output logic [hsv_pkg::HUE_BITS-1:0]  hue,
  output logic [COMPONENT_BITS-1:0]     saturation,
  output logic [COMPONENT_BITS-1:0]     brightness
);
  import hsv_pkg::*;

  localparam int W = COMPONENT_BITS;
  localparam int STEPS = (W > MIN_STEPS) ? W : MIN_STEPS;

  hsv_ctl_t     ctl     [0:STEPS];
  logic [W-1:0] sat_div [0:STEPS];
  logic [W-1:0] hue_div [0:STEPS];
  logic [W-1:0] sat_rem [0:STEPS];
  logic [W-1:0] hue_rem [0:STEPS];
  logic [STEPS-1:0] sat_dvd [0:STEPS];
  logic [STEPS-1:0] hue_dvd [0:STEPS];

  // The pipeline never refuses a beat.
  assign busy = 1'b0;

  // Extremes, sector and dividends.
  hsv_front #(.W(W), .S(STEPS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .red     (red),
    .green   (green),
    .blue    (blue),
    .ctl     (ctl[0]),
    .sat_div (sat_div[0]),
    .hue_div (hue_div[0]),
    .sat_rem (sat_rem[0]),
    .sat_dvd (sat_dvd[0]),
    .hue_rem (hue_rem[0]),
    .hue_dvd (hue_dvd[0])
  );

  // Row of divider cells, one quotient bit per cell.
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    hsv_div_cell #(.W(W), .S(STEPS)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl_in      (ctl[i]),
      .sat_div_in  (sat_div[i]),
      .hue_div_in  (hue_div[i]),
      .sat_rem_in  (sat_rem[i]),
      .sat_dvd_in  (sat_dvd[i]),
      .hue_rem_in  (hue_rem[i]),
      .hue_dvd_in  (hue_dvd[i]),
      .ctl_out     (ctl[i+1]),
      .sat_div_out (sat_div[i+1]),
      .hue_div_out (hue_div[i+1]),
      .sat_rem_out (sat_rem[i+1]),
      .sat_dvd_out (sat_dvd[i+1]),
      .hue_rem_out (hue_rem[i+1]),
      .hue_dvd_out (hue_dvd[i+1])
    );
  end

  // Final hue assembly and output register.
  hsv_back #(.W(W), .S(STEPS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl[STEPS]),
    .value_in   (sat_div[STEPS]),
    .sat_quo    (sat_dvd[STEPS]),
    .hue_quo    (hue_dvd[STEPS]),
    .done       (done),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

endmodule
